// ===== rtl/dpwg_pkg.sv =====
package dpwg_pkg;

    localparam int NUM_REGS     = 16;
    localparam int PACKET_BYTES = 16;

    localparam int REG_W   = 4;
    localparam int BYTE_W  = $clog2(PACKET_BYTES);
    localparam int SLOTS   = NUM_REGS * 2;
    localparam int RAM_AW  = REG_W + 1 + BYTE_W;
    localparam int RAM_DEP = SLOTS * PACKET_BYTES;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_COMMIT = 2'd2;

    localparam logic [1:0] CFG_TRACK_ENABLE = 2'd0;
    localparam logic [1:0] CFG_ONE_HALF     = 2'd1;
    localparam logic [1:0] CFG_ZERO_HALF    = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } dpwg_state_t;

    typedef struct packed
    {
        logic             fetch;
        logic             write;
        logic             commit;
        logic [REG_W-1:0] reg_idx;
        logic [3:0]       byte_idx;
        logic [7:0]       byte_value;
        logic [7:0]       bit_count;
        logic [7:0]       repeat_count;
    } dpwg_req_t;

    typedef struct packed
    {
        logic             accepted;
        logic             next_valid;
        logic [REG_W-1:0] cur_reg;
        logic             beyond_end;
        logic [2:0]       bit_sel;
    } dpwg_stat_t;

endpackage

// ===== rtl/dcc_packet_bit_waveform_generator.sv =====
// Channel   Direction  Handshake            Payload
// item      in         start & !busy        func, reg_index, byte_index, byte_value,
//                                           bit_count, repeat_count
// result    out        done (one cycle)     signal_level, toggled, bit_started, bit_value,
//                                           accepted, commit_pending, current_register
// config    in         cfg_valid&cfg_ready  cfg_index, cfg_data
//
// Every item is taken only while idle: the acceptance edge updates the
// bookkeeping and issues the packet byte read, and the result is shown in the
// following cycle while the read data arrives from the registered byte memory.
// Reset is asynchronous; the byte memory is not cleared, so the block is ready
// at once. The receiver cannot stall: each result is taken on its strobe cycle.
module dcc_packet_bit_waveform_generator import dpwg_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       func,
    input  logic [3:0]       reg_index,
    input  logic [3:0]       byte_index,
    input  logic [7:0]       byte_value,
    input  logic [7:0]       bit_count,
    input  logic [7:0]       repeat_count,
    output logic             done,
    output logic             signal_level,
    output logic             toggled,
    output logic             bit_started,
    output logic             bit_value,
    output logic             accepted,
    output logic             commit_pending,
    output logic [3:0]       current_register,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [3:0]       cfg_data
);

    dpwg_state_t state_reg;
    dpwg_state_t state_next;

    logic       enable_reg;
    logic [3:0] one_reg;
    logic [3:0] zero_reg;

    logic [4:0] ticks_reg;
    logic [3:0] half_reg;
    logic       level_reg;
    logic       sent_reg;
    logic       toggled_reg;
    logic       fetch_reg;
    logic       accepted_reg;

    logic       take;
    logic       tick_en;
    logic [4:0] ticks_dec;
    logic       toggle;
    logic       fetch;
    logic       bit_now;
    logic [3:0] half_sel;
    logic [3:0] half_use;

    dpwg_req_t         req;
    dpwg_stat_t        stat;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign busy      = (state_reg != ST_IDLE);
    assign take      = start && (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign tick_en   = (func == FUNC_TICK) && enable_reg;
    assign ticks_dec = ticks_reg - 5'd1;
    assign toggle    = tick_en && ((ticks_dec == {1'b0, half_reg}) || (ticks_dec == 5'd0));
    assign fetch     = tick_en && (ticks_dec == 5'd0);

    assign req.fetch        = fetch;
    assign req.write        = (func == FUNC_WRITE);
    assign req.commit       = (func == FUNC_COMMIT);
    assign req.reg_idx      = reg_index;
    assign req.byte_idx     = byte_index;
    assign req.byte_value   = byte_value;
    assign req.bit_count    = bit_count;
    assign req.repeat_count = repeat_count;

    dpwg_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (take),
        .req       (req),
        .stat      (stat),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    dpwg_byte_ram #(
        .DEPTH (RAM_DEP),
        .WIDTH (8),
        .AW    (RAM_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Bits past the end of the packet buffer are sent as zero.
    assign bit_now  = !stat.beyond_end && ram_rdata[3'd7 - stat.bit_sel];
    assign half_sel = bit_now ? one_reg : zero_reg;
    assign half_use = (half_sel == 4'd0) ? 4'd1 : half_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            one_reg    <= 4'd1;
            zero_reg   <= 4'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TRACK_ENABLE: enable_reg <= cfg_data[0];
                CFG_ONE_HALF:     one_reg    <= cfg_data;
                CFG_ZERO_HALF:    zero_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg    <= 5'd1;
            half_reg     <= 4'd0;
            level_reg    <= 1'b0;
            sent_reg     <= 1'b0;
            toggled_reg  <= 1'b0;
            fetch_reg    <= 1'b0;
            accepted_reg <= 1'b0;
        end
        else if (take)
        begin
            toggled_reg  <= toggle;
            fetch_reg    <= fetch;
            accepted_reg <= stat.accepted;
            if (toggle)
            begin
                level_reg <= ~level_reg;
            end
            if (tick_en)
            begin
                ticks_reg <= ticks_dec;
            end
        end
        else if (state_reg == ST_EXEC && fetch_reg)
        begin
            sent_reg  <= bit_now;
            half_reg  <= half_use;
            ticks_reg <= {half_use, 1'b0};
        end
    end

    assign done             = (state_reg == ST_EXEC);
    assign signal_level     = level_reg;
    assign toggled          = toggled_reg;
    assign bit_started      = fetch_reg;
    assign bit_value        = fetch_reg ? bit_now : sent_reg;
    assign accepted         = accepted_reg;
    assign commit_pending   = stat.next_valid;
    assign current_register = stat.cur_reg;

    a_done_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take))
        else $error("result strobe without an accepted item");

    a_fetch_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        done && bit_started |-> toggled && !accepted)
        else $error("bit fetch without a toggle");

    a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> ticks_reg != 5'd0)
        else $error("tick counter left at zero");

    a_reload_period: assert property (@(posedge clk) disable iff (!rst_n)
        done && bit_started |=> ticks_reg == {half_reg, 1'b0} && half_reg != 4'd0)
        else $error("bit period not reloaded");

endmodule

// ===== rtl/dpwg_byte_ram.sv =====
module dpwg_byte_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dpwg_sched.sv =====
module dpwg_sched import dpwg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  dpwg_req_t         req,
    output dpwg_stat_t        stat,
    output logic              ram_we,
    output logic [RAM_AW-1:0] ram_addr,
    output logic [7:0]        ram_wdata
);

    logic [7:0]       cnt_reg [SLOTS];
    logic             act_reg [NUM_REGS];
    logic [REG_W-1:0] cur_reg;
    logic [REG_W-1:0] cur_next;
    logic [REG_W-1:0] nreg_reg;
    logic             nv_reg;
    logic             nv_next;
    logic [REG_W-1:0] max_reg;
    logic [7:0]       rep_reg;
    logic [7:0]       rep_next;
    logic [7:0]       pos_reg;
    logic [7:0]       pos_base;
    logic             beyond_reg;
    logic [2:0]       sel_reg;

    logic             pkt_end;
    logic             swap;
    logic             new_act;
    logic             reg_ok;
    logic             byte_ok;
    logic             write_ok;
    logic             commit_ok;
    logic [RAM_AW-1:0] rd_addr;

    assign reg_ok    = ({1'b0, req.reg_idx} < (REG_W + 1)'(NUM_REGS));
    assign byte_ok   = ({1'b0, req.byte_idx} < 5'(PACKET_BYTES));
    assign write_ok  = req.write && reg_ok && byte_ok;
    assign commit_ok = req.commit && reg_ok && !nv_reg;
    assign pkt_end   = (pos_reg >= cnt_reg[{cur_reg, act_reg[cur_reg]}]);

    always_comb
    begin
        cur_next = cur_reg;
        nv_next  = nv_reg;
        rep_next = rep_reg;
        pos_base = pos_reg;
        swap     = 1'b0;
        if (req.fetch && pkt_end)
        begin
            pos_base = 8'd0;
            if (rep_reg != 8'd0 && cur_reg == '0)
            begin
                rep_next = rep_reg - 8'd1;
            end
            else if (nv_reg)
            begin
                cur_next = nreg_reg;
                nv_next  = 1'b0;
                swap     = 1'b1;
            end
            else if (cur_reg == max_reg)
            begin
                cur_next = REG_W'(1);
            end
            else if (cur_reg == REG_W'(NUM_REGS - 1))
            begin
                cur_next = '0;
            end
            else
            begin
                cur_next = cur_reg + REG_W'(1);
            end
        end
        new_act = swap ? ~act_reg[nreg_reg] : act_reg[cur_next];
        rd_addr = {cur_next, new_act, pos_base[BYTE_W+2:3]};
    end

    // Writes go to the buffer that is not being sent.
    assign ram_we    = go && write_ok;
    assign ram_wdata = req.byte_value;
    assign ram_addr  = req.write ? {req.reg_idx, ~act_reg[req.reg_idx], req.byte_idx[BYTE_W-1:0]}
                                 : rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                cnt_reg[i] <= 8'd0;
            end
            for (int i = 0; i < NUM_REGS; i++)
            begin
                act_reg[i] <= 1'b0;
            end
            cur_reg    <= '0;
            nreg_reg   <= '0;
            nv_reg     <= 1'b0;
            max_reg    <= '0;
            rep_reg    <= 8'd0;
            pos_reg    <= 8'd0;
            beyond_reg <= 1'b0;
            sel_reg    <= 3'd0;
        end
        else if (go)
        begin
            if (req.fetch)
            begin
                cur_reg    <= cur_next;
                nv_reg     <= nv_next;
                rep_reg    <= rep_next;
                pos_reg    <= pos_base + 8'd1;
                beyond_reg <= ((pos_base >> 3) >= 8'(PACKET_BYTES));
                sel_reg    <= pos_base[2:0];
                if (swap)
                begin
                    act_reg[nreg_reg] <= ~act_reg[nreg_reg];
                end
            end
            if (commit_ok)
            begin
                cnt_reg[{req.reg_idx, ~act_reg[req.reg_idx]}] <= req.bit_count;
                nreg_reg <= req.reg_idx;
                nv_reg   <= 1'b1;
                rep_reg  <= req.repeat_count;
                if (req.reg_idx > max_reg)
                begin
                    max_reg <= req.reg_idx;
                end
            end
        end
    end

    assign stat.accepted   = write_ok || commit_ok;
    assign stat.next_valid = nv_reg;
    assign stat.cur_reg    = cur_reg;
    assign stat.beyond_end = beyond_reg;
    assign stat.bit_sel    = sel_reg;

    a_pending_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(nv_reg) |-> $past(go && req.commit))
        else $error("pending flag set without a commit");

    a_swap_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(nv_reg) |-> $past(go && req.fetch) && cur_reg == $past(nreg_reg))
        else $error("pending register not swapped in");

endmodule
